// ===== rtl/ordered_list_insert_find_defines.svh =====
// assertion macros shared by the ordered list rtl
// expects clk and arst_n in the scope of each use
`ifndef ORDERED_LIST_INSERT_FIND_DEFINES_SVH
`define ORDERED_LIST_INSERT_FIND_DEFINES_SVH

// same-cycle implication, checked out of reset only
`define OLIF_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked out of reset only
`define OLIF_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/olif_pkg.sv =====
// types, constants and helpers for the ordered list block
// no dependencies
package olif_pkg;

	localparam int MAX_ENTRIES = 16;
	localparam int IDX_W       = $clog2(MAX_ENTRIES);
	localparam int CNT_W       = 5;
	localparam int DATA_W      = 32;

	typedef enum logic [1:0] {
		FUNC_INSERT = 2'd0,
		FUNC_FIND   = 2'd1,
		FUNC_GET    = 2'd2,
		FUNC_NOP    = 2'd3
	} func_t;

	typedef struct packed {
		func_t                     func;
		logic [4:0]                position;
		logic signed [DATA_W-1:0]  value;
	} req_t;

	typedef struct packed {
		logic                      ok;
		logic [4:0]                found_position;
		logic signed [DATA_W-1:0]  read_value;
		logic [4:0]                list_length;
		logic                      empty_res;
	} rsp_t;

	// per-cell update controls for one cycle
	typedef struct packed {
		logic load;
		logic shift;
	} cell_ctl_t;

	// index of the lowest set bit, zero when none is set
	function automatic logic [IDX_W-1:0] first_hit(input logic [MAX_ENTRIES-1:0] v);
		logic [IDX_W-1:0] idx;
		idx = '0;
		for (int i = MAX_ENTRIES - 1; i >= 0; i--) begin
			if (v[i]) begin
				idx = IDX_W'(i);
			end
		end
		return idx;
	endfunction

endpackage

// ===== rtl/olif_cell.sv =====
// one list entry: holds a word, loads or shifts from its lower neighbor, compares
// depends on olif_pkg
module olif_cell (
	input  logic                              clk,
	input  olif_pkg::cell_ctl_t               ctl,
	input  logic signed [olif_pkg::DATA_W-1:0] new_value,
	input  logic signed [olif_pkg::DATA_W-1:0] left_value,
	input  logic signed [olif_pkg::DATA_W-1:0] key,
	output logic signed [olif_pkg::DATA_W-1:0] entry,
	output logic                              hit
);

	logic signed [olif_pkg::DATA_W-1:0] data_q;

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			data_q <= new_value;
		end else if (ctl.shift) begin
			data_q <= left_value;
		end
	end

	assign entry = data_q;
	assign hit   = (data_q == key);

endmodule

// ===== rtl/ordered_list_insert_find.sv =====
// ordered list of signed words held in a row of cells, empty after reset
// timing: the request beat is registered in op_q and executes once the response register is free,
// and its result is registered in rsp_q, from which the response beat is taken
// throughput: one request per cycle; a stalled response beat holds the next request
// reset: list length 0, capacity register 16, both channels empty; entries are not cleared
// depends on olif_pkg, olif_cell and ordered_list_insert_find_defines.svh
`include "ordered_list_insert_find_defines.svh"

module ordered_list_insert_find (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_ready,
	input  olif_pkg::req_t   req,
	output logic             rsp_valid,
	input  logic             rsp_ready,
	output olif_pkg::rsp_t   rsp,
	input  logic             cfg_we,
	input  logic [4:0]       cfg_wdata
);

	localparam int N = olif_pkg::MAX_ENTRIES;
	localparam int IW = olif_pkg::IDX_W;
	localparam int CW = olif_pkg::CNT_W;

	logic                    op_valid_q;
	olif_pkg::req_t          op_q;
	logic                    rsp_valid_q;
	olif_pkg::rsp_t          rsp_q;
	logic [CW-1:0]           count_q;
	logic [4:0]              cap_q;

	logic                    exec;
	logic [CW-1:0]           cap_eff;
	logic                    ins_ok;
	logic                    get_ok;
	logic [IW-1:0]           slot;
	logic [N-1:0]            hits;
	logic [N-1:0]            live_hits;
	logic signed [olif_pkg::DATA_W-1:0] entries [N];
	olif_pkg::cell_ctl_t     ctl [N];
	olif_pkg::rsp_t          rsp_d;
	logic [CW-1:0]           count_d;

	assign exec      = op_valid_q && (!rsp_valid_q || rsp_ready);
	assign req_ready = !op_valid_q || exec;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_valid_q <= 1'b0;
		end else if (req_valid && req_ready) begin
			op_valid_q <= 1'b1;
		end else if (exec) begin
			op_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			op_q <= req;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= 5'd16;
		end else if (cfg_we) begin
			cap_q <= cfg_wdata;
		end
	end

	assign cap_eff = (cap_q > CW'(N)) ? CW'(N) : cap_q;

	assign slot   = IW'(op_q.position - 5'd1);
	assign ins_ok = exec && (op_q.func == olif_pkg::FUNC_INSERT) && (op_q.position != 5'd0)
		&& ({1'b0, op_q.position} <= ({1'b0, count_q} + 6'd1)) && (count_q < cap_eff);
	assign get_ok = (op_q.position != 5'd0) && (op_q.position <= count_q);

	for (genvar i = 0; i < N; i++) begin : g_cell
		// higher cells take their lower neighbor, the target cell takes the new word
		assign ctl[i].load  = ins_ok && (slot == IW'(i));
		assign ctl[i].shift = ins_ok && (slot < IW'(i));
		assign live_hits[i] = hits[i] && (CW'(i) < count_q);

		olif_cell u_cell (
			.clk        (clk),
			.ctl        (ctl[i]),
			.new_value  (op_q.value),
			.left_value ((i == 0) ? op_q.value : entries[(i == 0) ? 0 : i - 1]),
			.key        (op_q.value),
			.entry      (entries[i]),
			.hit        (hits[i])
		);
	end

	assign count_d = count_q + CW'(ins_ok);

	always_comb begin
		rsp_d                = '0;
		rsp_d.list_length    = count_d;
		rsp_d.empty_res      = (count_d == '0);
		unique case (op_q.func)
			olif_pkg::FUNC_INSERT: begin
				rsp_d.ok = ins_ok;
			end
			olif_pkg::FUNC_FIND: begin
				rsp_d.ok = |live_hits;
				if (|live_hits) begin
					rsp_d.found_position = 5'(olif_pkg::first_hit(live_hits)) + 5'd1;
				end
			end
			olif_pkg::FUNC_GET: begin
				rsp_d.ok = get_ok;
				if (get_ok) begin
					rsp_d.read_value = entries[slot];
				end
			end
			default: begin
				rsp_d.ok = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			count_q <= count_d;
			if (exec) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (exec) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	`OLIF_ASSERT_NOW(a_count_bound, 1'b1, count_q <= CW'(N), "list length above capacity")
	`OLIF_ASSERT_NEXT(a_count_step, ins_ok, count_q == $past(count_q) + CW'(1), "insert lost")
	`OLIF_ASSERT_NEXT(a_count_hold, !ins_ok, $stable(count_q), "length moved without insert")
	`OLIF_ASSERT_NOW(a_found_ok, rsp_valid_q && (rsp_q.found_position != 5'd0), rsp_q.ok, "find position without match")
	`OLIF_ASSERT_NOW(a_empty, rsp_valid_q, rsp_q.empty_res == (rsp_q.list_length == 5'd0), "empty flag disagrees with length")

endmodule
